@@ rtl/tli_pkg.sv @@
package tli_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths
   localparam int IDX_W = 10;
   localparam int ABS_W = 20;
   localparam int VAL_W = 32;
   localparam int NUM_W = ABS_W + VAL_W;

   // Entries-in-use register
   localparam int              CSR_W     = 11;
   localparam logic [CSR_W-1:0] CSR_RESET = 11'd2;
   localparam int              MIN_USED  = 2;

   // Front queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Serial divider: one quotient bit per step
   localparam int DIV_STEPS = VAL_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Request type code on the input channel
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } req_kind_type;

   // One classified item; abscissa is the load point or the query point
   typedef struct packed {
      req_kind_type     kind;
      logic [IDX_W-1:0] index;
      logic [ABS_W-1:0] abscissa;
      logic [VAL_W-1:0] value;
   } item_type;

endpackage

@@ rtl/tli_ram.sv @@
module tli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/tli_front.sv @@
module tli_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_type,
   input  logic [tli_pkg::IDX_W-1:0] req_entry_index,
   input  logic [tli_pkg::ABS_W-1:0] req_point_abscissa,
   input  logic [tli_pkg::VAL_W-1:0] req_point_value,
   input  logic [tli_pkg::ABS_W-1:0] req_query_abscissa,
   output logic                      head_valid,
   output tli_pkg::item_type         head_item,
   input  logic                      head_pop
);

   tli_pkg::item_type                 slots_ff [tli_pkg::QUEUE_DEPTH];
   tli_pkg::item_type                 item;
   logic [tli_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [tli_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [tli_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              accept;
   logic                              take;

   // Classify: a query carries its own abscissa, a load the point's
   always_comb begin
      item.kind     = (req_type == tli_pkg::REQ_QUERY) ? tli_pkg::KIND_QUERY
                                                       : tli_pkg::KIND_LOAD;
      item.index    = req_entry_index;
      item.abscissa = (req_type == tli_pkg::REQ_QUERY) ? req_query_abscissa
                                                       : req_point_abscissa;
      item.value    = req_point_value;
   end

   assign full       = (count_ff == tli_pkg::QCNT_W'(tli_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slots_ff[rd_ptr_ff];
   assign accept     = push && !full;
   assign take       = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == tli_pkg::QPTR_W'(tli_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == tli_pkg::QPTR_W'(tli_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + 1'b1;
      end
      if (accept && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slots_ff[wr_ptr_ff] <= item;
      end
   end

`ifndef SYNTHESIS
   a_full_holds_count: assert property (@(posedge clock) disable iff (reset)
      (push && full && !head_pop) |=> $stable(count_ff))
      else $error("queue count changed on a refused beat");
`endif

endmodule

@@ rtl/tli_div.sv @@
module tli_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tli_pkg::NUM_W-1:0] num,
   input  logic [tli_pkg::ABS_W-1:0] den,
   output logic                      done,
   output logic [tli_pkg::VAL_W-1:0] quo
);

   // The quotient is known to fit VAL_W bits, so the upper numerator bits
   // are already below the divisor and seed the remainder.
   logic [tli_pkg::ABS_W-1:0]     rem_ff, rem_in;
   logic [tli_pkg::VAL_W-1:0]     q_ff, q_in;
   logic [tli_pkg::ABS_W-1:0]     den_ff, den_in;
   logic [tli_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [tli_pkg::ABS_W:0]       trial;
   logic                          fits;

   assign trial = {rem_ff, q_ff[tli_pkg::VAL_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num[tli_pkg::NUM_W-1:tli_pkg::VAL_W];
         q_in    = num[tli_pkg::VAL_W-1:0];
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? tli_pkg::ABS_W'(trial - {1'b0, den_ff})
                       : trial[tli_pkg::ABS_W-1:0];
         q_in   = {q_ff[tli_pkg::VAL_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tli_pkg::DIV_CNT_W'(tli_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

`ifndef SYNTHESIS
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
`endif

endmodule

@@ rtl/tli_back.sv @@
module tli_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  tli_pkg::item_type         head_item,
   output logic                      head_pop,
   input  logic                      csr_we,
   input  logic [tli_pkg::CSR_W-1:0] csr_wdata,
   output logic                      empty,
   input  logic                      pop,
   output logic [tli_pkg::VAL_W-1:0] rsp_interp_value,
   output logic                      rsp_in_range
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_FIRST = 9'b000000010,
      ST_LAST  = 9'b000000100,
      ST_SCAN  = 9'b000001000,
      ST_V0    = 9'b000010000,
      ST_V1    = 9'b000100000,
      ST_SUM   = 9'b001000000,
      ST_DIV   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [tli_pkg::CSR_W-1:0]   csr_ff, csr_in;
   logic [tli_pkg::CNT_W-1:0]   n_used;
   logic [tli_pkg::ADDR_W-1:0]  last_addr;

   logic [tli_pkg::ABS_W-1:0]   x_ff, x_in;
   logic [tli_pkg::ABS_W-1:0]   prev_ff, prev_in;
   logic [tli_pkg::ADDR_W-1:0]  j_ff, j_in;
   logic [tli_pkg::ABS_W-1:0]   dxl_ff, dxl_in;
   logic [tli_pkg::ABS_W-1:0]   dhx_ff, dhx_in;
   logic [tli_pkg::ABS_W-1:0]   d_ff, d_in;
   logic [tli_pkg::VAL_W-1:0]   vlo_ff, vlo_in;
   logic [tli_pkg::NUM_W-1:0]   p_hi_ff, p_hi_in;
   logic [tli_pkg::NUM_W-1:0]   p_lo_ff, p_lo_in;
   logic [tli_pkg::VAL_W-1:0]   res_value_ff, res_value_in;
   logic                        res_range_ff, res_range_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tli_pkg::VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                        rsp_range_ff, rsp_range_in;

   logic                        tab_we;
   logic [tli_pkg::ADDR_W-1:0]  tab_waddr;
   logic [tli_pkg::ADDR_W-1:0]  a_raddr;
   logic [tli_pkg::ADDR_W-1:0]  v_raddr;
   logic [tli_pkg::ABS_W-1:0]   a_rdata;
   logic [tli_pkg::VAL_W-1:0]   v_rdata;

   logic                        div_start;
   logic [tli_pkg::NUM_W-1:0]   div_num;
   logic                        div_done;
   logic [tli_pkg::VAL_W-1:0]   div_quo;

   // Clamp the entries-in-use register to the table
   always_comb begin
      if (int'(csr_ff) < tli_pkg::MIN_USED) begin
         n_used = tli_pkg::CNT_W'(tli_pkg::MIN_USED);
      end else if (int'(csr_ff) > tli_pkg::TABLE_DEPTH) begin
         n_used = tli_pkg::CNT_W'(tli_pkg::TABLE_DEPTH);
      end else begin
         n_used = tli_pkg::CNT_W'(csr_ff);
      end
   end

   assign last_addr = tli_pkg::ADDR_W'(n_used - 1'b1);
   assign tab_waddr = tli_pkg::ADDR_W'(head_item.index);
   assign div_num   = tli_pkg::NUM_W'(p_hi_ff + p_lo_ff);
   assign csr_in    = csr_we ? csr_wdata : csr_ff;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      prev_in      = prev_ff;
      j_in         = j_ff;
      dxl_in       = dxl_ff;
      dhx_in       = dhx_ff;
      d_in         = d_ff;
      vlo_in       = vlo_ff;
      p_hi_in      = p_hi_ff;
      p_lo_in      = p_lo_ff;
      res_value_in = res_value_ff;
      res_range_in = res_range_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_value_in = rsp_value_ff;
      rsp_range_in = rsp_range_ff;
      head_pop     = 1'b0;
      tab_we       = 1'b0;
      a_raddr      = '0;
      v_raddr      = '0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               if (head_item.kind == tli_pkg::KIND_LOAD) begin
                  // drop loads aimed past the table
                  tab_we = (int'(head_item.index) < tli_pkg::TABLE_DEPTH);
               end else begin
                  x_in     = head_item.abscissa;
                  a_raddr  = '0;
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            if (x_ff < a_rdata) begin
               res_value_in = '0;
               res_range_in = 1'b0;
               state_in     = ST_OUT;
            end else begin
               prev_in  = a_rdata;
               a_raddr  = last_addr;
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (x_ff >= a_rdata) begin
               res_value_in = '0;
               res_range_in = 1'b0;
               state_in     = ST_OUT;
            end else begin
               a_raddr  = tli_pkg::ADDR_W'(1);
               j_in     = tli_pkg::ADDR_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // a_rdata holds entry j; stop at the first interval that holds x
            if ((prev_ff <= x_ff) && (a_rdata > x_ff)) begin
               dxl_in   = x_ff - prev_ff;
               dhx_in   = a_rdata - x_ff;
               d_in     = a_rdata - prev_ff;
               v_raddr  = j_ff - 1'b1;
               state_in = ST_V0;
            end else begin
               prev_in = a_rdata;
               j_in    = j_ff + 1'b1;
               a_raddr = j_ff + 1'b1;
            end
         end
         ST_V0: begin
            vlo_in   = v_rdata;
            v_raddr  = j_ff;
            state_in = ST_V1;
         end
         ST_V1: begin
            p_hi_in  = tli_pkg::NUM_W'(dxl_ff) * tli_pkg::NUM_W'(v_rdata);
            p_lo_in  = tli_pkg::NUM_W'(dhx_ff) * tli_pkg::NUM_W'(vlo_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               res_value_in = div_quo;
               res_range_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the result register frees up
            if (!rsp_valid_ff || pop) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_range_in = res_range_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= tli_pkg::CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      prev_ff      <= prev_in;
      j_ff         <= j_in;
      dxl_ff       <= dxl_in;
      dhx_ff       <= dhx_in;
      d_ff         <= d_in;
      vlo_ff       <= vlo_in;
      p_hi_ff      <= p_hi_in;
      p_lo_ff      <= p_lo_in;
      res_value_ff <= res_value_in;
      res_range_ff <= res_range_in;
      rsp_value_ff <= rsp_value_in;
      rsp_range_ff <= rsp_range_in;
   end

   tli_ram #(
      .WIDTH (tli_pkg::ABS_W),
      .DEPTH (tli_pkg::TABLE_DEPTH)
   ) u_abscissa_ram (
      .clock (clock),
      .we    (tab_we),
      .waddr (tab_waddr),
      .wdata (head_item.abscissa),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   tli_ram #(
      .WIDTH (tli_pkg::VAL_W),
      .DEPTH (tli_pkg::TABLE_DEPTH)
   ) u_value_ram (
      .clock (clock),
      .we    (tab_we),
      .waddr (tab_waddr),
      .wdata (head_item.value),
      .raddr (v_raddr),
      .rdata (v_rdata)
   );

   tli_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (d_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign empty            = !rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_in_range     = rsp_range_ff;

`ifndef SYNTHESIS
   a_scan_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (j_ff != '0 && tli_pkg::CNT_W'(j_ff) < n_used))
      else $error("interval scan left the entries in use");
   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_range_ff) |-> (rsp_value_ff == '0))
      else $error("out-of-range result carries a nonzero value");
   a_div_only_on_hit: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (d_ff != '0))
      else $error("divider started with a zero-width interval");
`endif

endmodule

@@ rtl/table_linear_interpolator.sv @@
// Piecewise linear interpolation over a loaded table of (abscissa, value).
// Input channel (push/full): a beat is taken when push is high and full is
// low. req_type 0 loads slot req_entry_index with req_point_abscissa (U16.4)
// and req_point_value (Q16.16) and gives no result; req_type 1 queries at
// req_query_abscissa and gives one result beat.
// Result channel (empty/pop): the oldest result sits on rsp_interp_value and
// rsp_in_range while empty is low; pop takes it. A query outside the table
// span returns 0 with rsp_in_range low.
// csr_we/csr_wdata set the number of entries searched (clamped to 2..depth);
// write it only while the block is idle.
// Sequencing: a two-beat front queue feeds the sequencer. A load is
// written to the table when the idle sequencer takes it from the head. A
// query that hits interval i goes through one abscissa RAM read per entry
// scanned, two value reads, a multiply and a 32-step serial divide. An
// out-of-span query returns without a scan, after the first or last entry read.
// Reset empties both queues and sets the entry count to 2; table contents
// are not cleared and must be loaded before use. When the receiver stalls,
// one result waits in the output register while the next query is worked
// on; the sequencer then holds until that register frees up.
module table_linear_interpolator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_type,
   input  logic [tli_pkg::IDX_W-1:0] req_entry_index,
   input  logic [tli_pkg::ABS_W-1:0] req_point_abscissa,
   input  logic [tli_pkg::VAL_W-1:0] req_point_value,
   input  logic [tli_pkg::ABS_W-1:0] req_query_abscissa,
   output logic                      empty,
   input  logic                      pop,
   output logic [tli_pkg::VAL_W-1:0] rsp_interp_value,
   output logic                      rsp_in_range,
   input  logic                      csr_we,
   input  logic [tli_pkg::CSR_W-1:0] csr_wdata
);

   // Front-to-back queue head
   logic              head_valid;
   logic              head_pop;
   tli_pkg::item_type head_item;

   // Accept and classify beats, buffer them ahead of the sequencer
   tli_front u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_type           (req_type),
      .req_entry_index    (req_entry_index),
      .req_point_abscissa (req_point_abscissa),
      .req_point_value    (req_point_value),
      .req_query_abscissa (req_query_abscissa),
      .head_valid         (head_valid),
      .head_item          (head_item),
      .head_pop           (head_pop)
   );

   // Table storage, interval scan, interpolation and result register
   tli_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .head_pop         (head_pop),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .empty            (empty),
      .pop              (pop),
      .rsp_interp_value (rsp_interp_value),
      .rsp_in_range     (rsp_in_range)
   );

endmodule
